@@ hw/rtl/fsvd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsvd_pkg
// Shared constants, types, sine table and helpers of the vertex displacer.
// ----------------------------------------------------------------------------
package fsvd_pkg;

  localparam int MODE_LIMIT      = 15;
  localparam int SINE_INDEX_BITS = 10;
  localparam int TAB_N           = 1 << SINE_INDEX_BITS;
  localparam int LANES           = MODE_LIMIT + 1;
  localparam int GROUPS          = (LANES + 3) / 4;
  localparam int MODE_W          = 4;
  localparam int TERM_W          = 48;
  localparam int ACC_W           = TERM_W + $clog2(LANES) + 1;
  localparam int R_W             = ACC_W - 27;
  localparam int P_W             = R_W + 32;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;

  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_RADIUS = 3'd0,
    REG_AMPLITUDE   = 3'd1,
    REG_MIN_MODE    = 3'd2,
    REG_MAX_MODE    = 3'd3,
    REG_TIME_PHASE  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] amplitude;
    logic [MODE_W-1:0]  min_mode;
    logic [MODE_W-1:0]  max_mode;
    logic [15:0]        time_phase;
  } mode_cfg_t;

  typedef logic [14:0] sine_tab_t [0:TAB_N];

  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    return p[125:62];
  endfunction

  // restoring long division, used only while the table is built
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // taylor series in q2.62, evaluated at elaboration
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t    tab;
    logic [127:0] p;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [63:0]  den;
    logic [63:0]  rnd;
    for (int i = 0; i <= TAB_N; i++) begin
      p    = {64'b0, HALF_PI_Q62} * 128'(i);
      x    = p[SINE_INDEX_BITS+63:SINE_INDEX_BITS];
      x2   = mul_q62(x, x);
      term = x;
      sum  = x;
      for (int j = 1; j <= 12; j++) begin
        den  = 64'((2 * j) * (2 * j + 1));
        term = div_u64(mul_q62(term, x2), den);
        if (j[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      rnd    = (sum + 64'h0000_8000_0000_0000) >> 48;
      tab[i] = rnd[14:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  function automatic logic signed [15:0] sin16(logic [15:0] a);
    logic [SINE_INDEX_BITS-1:0] idx;
    logic [SINE_INDEX_BITS:0]   addr;
    logic signed [15:0]         v;
    idx  = a[13:14-SINE_INDEX_BITS];
    addr = a[14] ? (SINE_INDEX_BITS+1)'(TAB_N) - {1'b0, idx} : {1'b0, idx};
    v    = signed'({1'b0, SINE_TAB[addr]});
    return a[15] ? -v : v;
  endfunction

  function automatic logic signed [15:0] cos16(logic [15:0] a);
    return sin16(a + 16'd16384);
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [63:0] v);
    if (v > 64'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -64'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

@@ hw/rtl/fsvd_mode_sum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsvd_mode_sum
// One lane per mode: phases, table lookups, products, then a registered
// adder tree. Six register stages from angles to the summed displacement.
// ----------------------------------------------------------------------------
module fsvd_mode_sum
  import fsvd_pkg::*;
(
  input  logic                    clk,
  input  logic                    adv,
  input  logic [15:0]             polar,
  input  logic [15:0]             azimuth,
  input  mode_cfg_t               cfg,
  output logic signed [ACC_W-1:0] acc
);

  logic [MODE_W-1:0] top_mode;
  logic [15:0]       sph_r [LANES];
  logic [15:0]       cph_r [LANES];
  logic signed [15:0] s_r  [LANES];
  logic signed [15:0] c_r  [LANES];
  logic signed [31:0] sc_r [LANES];
  logic signed [TERM_W-1:0] term_r [LANES];
  logic signed [TERM_W-1:0] term_pad [GROUPS*4];
  logic signed [ACC_W-1:0]  grp_nxt [GROUPS];
  logic signed [ACC_W-1:0]  grp_r [GROUPS];
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  acc_r;
  logic [LANES-1:0] en1_r, en2_r, en3_r;
  logic signed [TERM_W-1:0] amp_ext;

  assign top_mode = (cfg.max_mode > MODE_W'(MODE_LIMIT)) ? MODE_W'(MODE_LIMIT) : cfg.max_mode;
  assign amp_ext  = TERM_W'(cfg.amplitude);

  for (genvar n = 0; n < LANES; n++) begin : g_lane
    always_ff @(posedge clk) begin
      if (adv) begin
        sph_r[n]  <= 16'(16'(n) * polar);
        cph_r[n]  <= 16'(16'(n - 1) * azimuth) + cfg.time_phase;
        en1_r[n]  <= (32'(cfg.min_mode) <= n) && (n <= 32'(top_mode));
        s_r[n]    <= sin16(sph_r[n]);
        c_r[n]    <= cos16(cph_r[n]);
        en2_r[n]  <= en1_r[n];
        sc_r[n]   <= s_r[n] * c_r[n];
        en3_r[n]  <= en2_r[n];
        term_r[n] <= en3_r[n] ? amp_ext * TERM_W'(sc_r[n]) : '0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < GROUPS * 4; i++) begin
      term_pad[i] = (i < LANES) ? term_r[i] : '0;
    end
    for (int g = 0; g < GROUPS; g++) begin
      grp_nxt[g] = ACC_W'(term_pad[4*g]) + ACC_W'(term_pad[4*g+1])
                 + ACC_W'(term_pad[4*g+2]) + ACC_W'(term_pad[4*g+3]);
    end
    acc_nxt = '0;
    for (int g = 0; g < GROUPS; g++) begin
      acc_nxt = acc_nxt + grp_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      grp_r <= grp_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

@@ hw/rtl/fourier_sphere_vertex_displacer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fourier_sphere_vertex_displacer
// Displaces sphere vertices by a sum of mode terms and returns position.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall carry one vertex beat (polar, azimuth angles).
//   out_valid/out_stall carry one result beat (x, y, z, displaced radius).
//   A beat moves at a clock edge with valid high and stall low.
//   cfg_we/cfg_index/cfg_wdata write the five registers; write only when
//   the pipeline is empty. Unknown indexes are ignored.
// Latency: nine register stages; a result is registered in the last of them
//   and driven straight onto the out_ ports.
// Throughput: one vertex per cycle; every mode has its own lane so the
//   nine-stage pipeline advances each cycle unless the output stalls.
// Reset: registers return to defaults and the pipeline empties.
// Stall: when a result waits under out_stall the whole pipeline holds and
//   in_stall rises in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module fourier_sphere_vertex_displacer
  import fsvd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [15:0]           in_polar_angle,
  input  logic [15:0]           in_azimuth_angle,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [15:0]    out_pos_x,
  output logic signed [15:0]    out_pos_y,
  output logic signed [15:0]    out_pos_z,
  output logic signed [15:0]    out_displaced_radius
);

  localparam int NSTG = 9;

  logic [14:0]        base_radius_r;
  logic signed [15:0] amplitude_r;
  logic [MODE_W-1:0]  min_mode_r;
  logic [MODE_W-1:0]  max_mode_r;
  logic [15:0]        time_phase_r;
  mode_cfg_t          mode_cfg;

  logic [NSTG-1:0] vld_r, vld_nxt;
  logic            adv;

  logic [15:0]        polar_r, az_r;
  logic signed [15:0] sp_r, cp_r, ca_r, sa_r;
  logic signed [31:0] spca_r [5];
  logic signed [31:0] spsa_r [5];
  logic signed [15:0] cpd_r  [5];
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [R_W-1:0]   r_r;
  logic signed [P_W-1:0]   px_r, py_r;
  logic signed [P_W-1:0]   pz_r;
  logic signed [P_W-1:0]   x_rnd, y_rnd, z_rnd;
  logic signed [15:0] pos_x_r, pos_y_r, pos_z_r, rad_r;
  logic signed [R_W-1:0]   r_d_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_radius_r <= 15'd4096;
      amplitude_r   <= 16'sd819;
      min_mode_r    <= MODE_W'(1);
      max_mode_r    <= MODE_W'(5);
      time_phase_r  <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_RADIUS: base_radius_r <= cfg_wdata[14:0];
        REG_AMPLITUDE:   amplitude_r   <= signed'(cfg_wdata);
        REG_MIN_MODE:    min_mode_r    <= cfg_wdata[MODE_W-1:0];
        REG_MAX_MODE:    max_mode_r    <= cfg_wdata[MODE_W-1:0];
        REG_TIME_PHASE:  time_phase_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign mode_cfg = '{amplitude: amplitude_r, min_mode: min_mode_r,
                      max_mode: max_mode_r, time_phase: time_phase_r};

  // whole pipeline moves unless a finished beat is held at the output
  assign adv      = !(vld_r[NSTG-1] && out_stall);
  assign in_stall = !adv;
  assign vld_nxt  = {vld_r[NSTG-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  fsvd_mode_sum u_mode_sum (
    .clk     (clk),
    .adv     (adv),
    .polar   (in_polar_angle),
    .azimuth (in_azimuth_angle),
    .cfg     (mode_cfg),
    .acc     (acc)
  );

  assign acc_rnd = (acc + signed'(ACC_W'(64'd1 << 27))) >>> 28;
  assign x_rnd   = (px_r + signed'(P_W'(64'd1 << 27))) >>> 28;
  assign y_rnd   = (py_r + signed'(P_W'(64'd1 << 27))) >>> 28;
  assign z_rnd   = (pz_r + signed'(P_W'(64'd1 << 13))) >>> 14;

  always_ff @(posedge clk) begin
    if (adv) begin
      polar_r   <= in_polar_angle;
      az_r      <= in_azimuth_angle;
      sp_r      <= sin16(polar_r);
      cp_r      <= cos16(polar_r);
      ca_r      <= cos16(az_r);
      sa_r      <= sin16(az_r);
      spca_r[0] <= sp_r * ca_r;
      spsa_r[0] <= sp_r * sa_r;
      cpd_r[0]  <= cp_r;
      for (int i = 1; i < 5; i++) begin
        spca_r[i] <= spca_r[i-1];
        spsa_r[i] <= spsa_r[i-1];
        cpd_r[i]  <= cpd_r[i-1];
      end
      r_r     <= R_W'(base_radius_r) + acc_rnd[R_W-1:0];
      px_r    <= P_W'(r_r) * P_W'(spca_r[4]);
      py_r    <= P_W'(r_r) * P_W'(spsa_r[4]);
      pz_r    <= P_W'(r_r) * P_W'(cpd_r[4]);
      r_d_r   <= r_r;
      pos_x_r <= sat16(64'(x_rnd));
      pos_y_r <= sat16(64'(y_rnd));
      pos_z_r <= sat16(64'(z_rnd));
      rad_r   <= sat16(64'(r_d_r));
    end
  end

  assign out_valid            = vld_r[NSTG-1];
  assign out_pos_x            = pos_x_r;
  assign out_pos_y            = pos_y_r;
  assign out_pos_z            = pos_z_r;
  assign out_displaced_radius = rad_r;

`ifndef SYNTH
  a_stall_only_on_held_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  a_pipe_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline valid bits moved during a stall");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule

@@ sim/tb_fourier_sphere_vertex_displacer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fourier_sphere_vertex_displacer
// Streams vertices through the displacer under random sender gaps and
// receiver stalls, predicts every position from its own table-driven model
// and compares each result field by field, over several register settings.
// ----------------------------------------------------------------------------
module tb_fourier_sphere_vertex_displacer;
  import fsvd_pkg::*;

  localparam int LATENCY   = 9;
  localparam int WD_LIMIT  = 2000;
  localparam int N_RANDOM  = 1500;
  localparam int N_TABLE   = 14;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [15:0] rad;
  } vertex_pos_t;

  typedef struct {
    logic [15:0] polar;
    logic [15:0] az;
    bit          known;
    vertex_pos_t pos;
  } vertex_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_polar_angle = '0;
  logic [15:0] in_azimuth_angle = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [15:0] out_pos_x, out_pos_y, out_pos_z, out_displaced_radius;

  fourier_sphere_vertex_displacer u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_polar_angle(in_polar_angle), .in_azimuth_angle(in_azimuth_angle),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_displaced_radius(out_displaced_radius)
  );

  always #4 clk = ~clk;

  // predictor copy of the registers
  logic [14:0]        m_radius;
  logic signed [15:0] m_amp;
  logic [3:0]         m_lo_mode;
  logic [3:0]         m_hi_mode;
  logic [15:0]        m_time;

  int          rom [0:TAB_N];
  vertex_pos_t expected_pos_q[$];
  int          n_mismatch = 0;
  int          n_checked = 0;
  int          idle_cycles = 0;
  bit          recv_stall_on = 1'b0;
  int          n_cfg_sets = 0;

  // sine quarter wave, taylor series in q2.62
  function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    return p[125:62];
  endfunction

  task automatic fill_rom();
    logic [127:0] p;
    logic [63:0] x, x2, t, s;
    for (int i = 0; i <= TAB_N; i++) begin
      p  = 128'(64'h6487ED5110B4611A) * 128'(i);
      x  = p[SINE_INDEX_BITS+63:SINE_INDEX_BITS];
      x2 = q62_mul(x, x);
      t  = x;
      s  = x;
      for (int j = 1; j <= 12; j++) begin
        t = q62_mul(t, x2) / 64'((2 * j) * (2 * j + 1));
        s = (j % 2) ? s - t : s + t;
      end
      rom[i] = int'((s + 64'h0000_8000_0000_0000) >> 48);
    end
  endtask

  function automatic longint sine_of(logic [15:0] a);
    int idx, v;
    idx = int'(a[13:0]) >> (14 - SINE_INDEX_BITS);
    v   = a[14] ? rom[TAB_N - idx] : rom[idx];
    return a[15] ? -v : v;
  endfunction

  function automatic longint cosine_of(logic [15:0] a);
    return sine_of(a + 16'd16384);
  endfunction

  // add half, then floor
  function automatic longint round_down(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic vertex_pos_t displace_vertex(logic [15:0] polar, logic [15:0] az);
    vertex_pos_t p;
    longint acc, r, sp;
    int top;
    logic [15:0] sph, cph;
    acc = 0;
    top = (m_hi_mode > MODE_LIMIT) ? MODE_LIMIT : int'(m_hi_mode);
    for (int n = int'(m_lo_mode); n <= top; n++) begin
      sph = 16'(n * polar);
      cph = 16'((n - 1) * int'(az)) + m_time;
      acc += longint'(m_amp) * sine_of(sph) * cosine_of(cph);
    end
    r  = longint'(m_radius) + round_down(acc, 28);
    sp = sine_of(polar);
    p.x   = clip16(round_down(r * sp * cosine_of(az), 28));
    p.y   = clip16(round_down(r * sp * sine_of(az), 28));
    p.z   = clip16(round_down(r * cosine_of(polar), 14));
    p.rad = clip16(r);
    return p;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_BASE_RADIUS: m_radius  = val[14:0];
      REG_AMPLITUDE:   m_amp     = val;
      REG_MIN_MODE:    m_lo_mode = val[3:0];
      REG_MAX_MODE:    m_hi_mode = val[3:0];
      REG_TIME_PHASE:  m_time    = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(logic [15:0] rad, logic [15:0] amp, logic [3:0] lo,
                               logic [3:0] hi, logic [15:0] ph);
    write_reg(REG_BASE_RADIUS, rad);
    write_reg(REG_AMPLITUDE, amp);
    write_reg(REG_MIN_MODE, {12'b0, lo});
    write_reg(REG_MAX_MODE, {12'b0, hi});
    write_reg(REG_TIME_PHASE, ph);
    n_cfg_sets++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_pos_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  // drive one vertex beat; stays on the bus until accepted, and valid stays
  // up afterwards so a following beat can go out back to back
  task automatic send_vertex(logic [15:0] polar, logic [15:0] az);
    in_valid         <= 1'b1;
    in_polar_angle   <= polar;
    in_azimuth_angle <= az;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_pos_q = {expected_pos_q, displace_vertex(polar, az)};
    @(negedge clk);
  endtask

  task automatic send_burst(int count, bit favor_edges);
    logic [15:0] p, a;
    for (int i = 0; i < count; i++) begin
      p = 16'($urandom_range(32768, 0));
      a = 16'($urandom);
      if (favor_edges && $urandom_range(3, 0) == 0) p = 16'($urandom);  // beyond pi
      if (favor_edges && $urandom_range(7, 0) == 0) a = {2'($urandom_range(3, 0)), 14'h0};
      send_vertex(p, a);
      if (!(i % 40 == 0) && $urandom_range(5, 0) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(6, 1)) @(negedge clk);
      end
    end
  endtask

  // receiver stall pattern: alternating stretches of stalls and free flow
  always @(negedge clk) begin
    if ($urandom_range(15, 0) == 0) recv_stall_on <= ~recv_stall_on;
    out_stall <= recv_stall_on ? ($urandom_range(2, 0) != 0) : 1'b0;
  end

  always @(posedge clk) begin
    vertex_pos_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_pos_x, out_pos_y, out_pos_z, out_displaced_radius};
      if (expected_pos_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = expected_pos_q.pop_front();
        n_checked++;
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: x %0d/%0d y %0d/%0d z %0d/%0d r %0d/%0d (exp/act)",
                     want.x, got.x, want.y, got.y, want.z, got.z, want.rad, got.rad);
        end
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("watchdog expired, %0d results outstanding", expected_pos_q.size());
      $display("fourier_sphere_vertex_displacer regression: fail");
      $finish;
    end
  end

  vertex_row_t table_rows [N_TABLE];

  initial begin
    vertex_pos_t got_ref;
    fill_rom();
    m_radius = 15'd4096; m_amp = 16'sd819; m_lo_mode = 4'd1; m_hi_mode = 4'd5;
    m_time = 16'd0;
    // with the reset radius at the two poles the position is read off
    table_rows = '{
      '{16'd0,     16'd0,     1'b1, '{16'sd0, 16'sd0, 16'sd4096, 16'sd4096}},
      '{16'd32768, 16'd0,     1'b1, '{16'sd0, 16'sd0, -16'sd4096, 16'sd4096}},
      '{16'd16384, 16'd0,     1'b0, '0},
      '{16'd16384, 16'd16384, 1'b0, '0},
      '{16'd16384, 16'd32768, 1'b0, '0},
      '{16'd16384, 16'd49152, 1'b0, '0},
      '{16'd16384, 16'hFFFF,  1'b0, '0},
      '{16'd8192,  16'd8192,  1'b0, '0},
      '{16'hFFFF,  16'hFFFF,  1'b0, '0},
      '{16'hC000,  16'h1234,  1'b0, '0},
      '{16'd1,     16'd1,     1'b0, '0},
      '{16'h5555,  16'hAAAA,  1'b0, '0},
      '{16'h2AAA,  16'h5555,  1'b0, '0},
      '{16'd32767, 16'h8000,  1'b0, '0}
    };
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_TABLE; i++) begin
      if (table_rows[i].known) begin
        got_ref = displace_vertex(table_rows[i].polar, table_rows[i].az);
        if (got_ref !== table_rows[i].pos) begin
          n_mismatch++;
          $display("table row %0d disagrees with predictor", i);
        end
      end
      send_vertex(table_rows[i].polar, table_rows[i].az);
    end
    drain();

    // extremes: saturation, negative amplitude, mode zero, full range
    apply_setting(16'h7FFF, 16'h7FFF, 4'd0, 4'd15, 16'hFFFF);
    for (int i = 0; i < N_TABLE; i++) send_vertex(table_rows[i].polar, table_rows[i].az);
    drain();
    apply_setting(16'd0, 16'h8000, 4'd0, 4'd15, 16'd0);
    for (int i = 0; i < N_TABLE; i++) send_vertex(table_rows[i].polar, table_rows[i].az);
    drain();
    // empty mode range
    apply_setting(16'd2048, 16'h7FFF, 4'd9, 4'd3, 16'h4000);
    for (int i = 0; i < 6; i++) send_vertex(table_rows[i].polar, table_rows[i].az);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      apply_setting(16'($urandom_range(32767, 0)), 16'($urandom),
                    4'($urandom_range(15, 0)), 4'($urandom_range(15, 0)),
                    16'($urandom));
      for (int done = 0; done < N_RANDOM / 6; ) begin
        int len;
        int gap;
        len = $urandom_range(40, 1);
        send_burst(len, 1'b1);
        done += len;
        gap = $urandom_range(12, 0);
        // sender gap, sometimes a full wait for the pipeline to empty
        if ($urandom_range(9, 0) == 0) begin
          drain();
        end else if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      drain();
    end

    $display("checked %0d vertices over %0d register settings, incl. saturation,",
             n_checked, n_cfg_sets + 1);
    $display("empty mode range, mode zero and polar angles beyond pi");
    if (n_mismatch == 0 && expected_pos_q.size() == 0) begin
      $display("fourier_sphere_vertex_displacer regression: pass");
    end else begin
      $display("fourier_sphere_vertex_displacer regression: fail");
    end
    $finish;
  end

endmodule
